// ===== rtl/core/cfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_pkg: shared constants for the continued-fraction expander
// Fixed field widths of the request and result channels.
// ----------------------------------------------------------------------------
package cfe_pkg;

	localparam int RAD_W   = 32;	// radicand field
	localparam int LIM_W   = 6;		// iteration_limit field
	localparam int QUOT_W  = 17;	// quotient field
	localparam int IDX_W   = 6;		// term_index and period_length fields

endpackage

// ===== rtl/core/cfe_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_isqrt: bit-serial integer square root
// Digit-by-digit root, two radicand bits per cycle, one root bit per cycle.
// ----------------------------------------------------------------------------
module cfe_isqrt #(
	parameter int ROOT_W = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2*ROOT_W-1:0]   value,
	output logic                  done,
	output logic [ROOT_W-1:0]     root,
	output logic                  exact
);

	localparam int VW = 2 * ROOT_W;
	localparam int RW = ROOT_W + 1;		// partial remainder
	localparam int SW = ROOT_W + 3;		// shifted remainder / trial
	localparam int CW = $clog2(ROOT_W + 1);

	logic [VW-1:0]     rad_q;
	logic [RW-1:0]     rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [SW-1:0] rem_sh;
	logic [SW-1:0] trial;
	logic          take;

	assign rem_sh = {rem_q, rad_q[VW-1 -: 2]};
	assign trial  = SW'({root_q, 2'b01});
	assign take   = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[VW-3:0], 2'b00};
			rem_q  <= take ? RW'(rem_sh - trial) : RW'(rem_sh);
			root_q <= {root_q[ROOT_W-2:0], take};
		end
	end

	assign done  = done_q;
	assign root  = root_q;
	assign exact = (rem_q == '0);

endmodule

// ===== rtl/core/cfe_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_mac: bit-serial signed multiply-accumulate
// acc = addend + mult * mcand, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module cfe_mac #(
	parameter int MULT_W = 17,
	parameter int ACC_W  = 35
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [ACC_W-1:0] addend,
	input  logic signed [ACC_W-1:0] mcand,
	input  logic [MULT_W-1:0]       mult,
	output logic                    done,
	output logic signed [ACC_W-1:0] acc
);

	localparam int CW = $clog2(MULT_W + 1);

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] mc_q;
	logic [MULT_W-1:0]       mp_q;
	logic [CW-1:0]           cnt_q;
	logic                    busy_q;
	logic                    done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(MULT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= addend;
			mc_q  <= mcand;
			mp_q  <= mult;
		end else if (busy_q) begin
			if (mp_q[0]) begin
				acc_q <= acc_q + mc_q;
			end
			mc_q <= mc_q <<< 1;
			mp_q <= mp_q >> 1;
		end
	end

	assign done = done_q;
	assign acc  = acc_q;

endmodule

// ===== rtl/core/cfe_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_div: bit-serial restoring divider
// One quotient bit per cycle, MSB first; divisor must be nonzero.
// ----------------------------------------------------------------------------
module cfe_div #(
	parameter int DIV_W = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quot,
	output logic [DIV_W-1:0] rem
);

	localparam int CW = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] dvd_q;	// dividend bits shift out, quotient bits shift in
	logic [DIV_W-1:0] dvs_q;
	logic [DIV_W-1:0] rem_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DIV_W:0] rem_sh;
	logic           fits;

	assign rem_sh = {rem_q, dvd_q[DIV_W-1]};
	assign fits   = (rem_sh >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DIV_W'(rem_sh - {1'b0, dvs_q}) : DIV_W'(rem_sh);
			dvd_q <= {dvd_q[DIV_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = dvd_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/core/sqrt_continued_fraction_expander_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqrt_continued_fraction_expander_top: continued fraction of sqrt(d)
// Emits the partial quotients of sqrt(radicand) as a run of result transfers.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------------
//  request | req_valid/req_ready | radicand, iteration_limit
//  result  | res_valid/res_ready | quotient, term_index, last, period_length,
//          |                     | square_error
//
// One request at a time; req_ready is high only while the sequencer is idle,
// which includes while the final result of the previous run still waits.
// With H = ceil(RADICAND_BITS/2) and N = H+1: the bit-serial root runs first,
// then every further term is a serial multiply-accumulate over N multiplier
// bits, a serial divide producing N quotient bits, and sequencing.
// A stalled result holds the sequencer in its emit state; nothing is dropped.
// Reset clears the sequencer, unit counters and the result valid flag.
//
// Recurrence used per term (no wide multiply, one narrow divide):
//   m'  = a0 - r               (r = remainder of the previous divide)
//   q'  = q_prev + a*(m - m')  (starting with q_prev = d, q = 1, m = 0, r = 0)
//   a'  = (a0 + m') div q',  r' = (a0 + m') mod q'
// ----------------------------------------------------------------------------
module sqrt_continued_fraction_expander_top #(
	parameter int RADICAND_BITS  = 32,
	parameter int MAX_ITERATIONS = 63
) (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic [cfe_pkg::RAD_W-1:0]   radicand,
	input  logic [cfe_pkg::LIM_W-1:0]   iteration_limit,

	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [cfe_pkg::QUOT_W-1:0]  quotient,
	output logic [cfe_pkg::IDX_W-1:0]   term_index,
	output logic                        last,
	output logic [cfe_pkg::IDX_W-1:0]   period_length,
	output logic                        square_error
);

	localparam int W   = RADICAND_BITS;
	localparam int H   = (W + 1) / 2;	// root width
	localparam int N   = H + 1;		// width of q, a, r and a0+m
	localparam int VW  = 2 * H;		// radicand padded for the root unit
	localparam int PW  = W + 3;		// signed accumulator for q'
	localparam int RW  = cfe_pkg::RAD_W;
	localparam int LW  = cfe_pkg::LIM_W;
	localparam int QW  = cfe_pkg::QUOT_W;
	localparam int IW  = cfe_pkg::IDX_W;

	// sequencer codes
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ROOT  = 3'd1;
	localparam logic [2:0] S_EMIT0 = 3'd2;
	localparam logic [2:0] S_STEP  = 3'd3;
	localparam logic [2:0] S_MUL   = 3'd4;
	localparam logic [2:0] S_DIV   = 3'd5;
	localparam logic [2:0] S_EMIT  = 3'd6;

	logic [2:0] state_q;

	// request and recurrence state
	logic [W-1:0]  d_q;
	logic [LW-1:0] lim_q;
	logic [H-1:0]  a0_q;
	logic          sq_q;
	logic [H-1:0]  m_q;
	logic [H-1:0]  mn_q;
	logic [N-1:0]  q_q;
	logic [W-1:0]  qp_q;
	logic [N-1:0]  a_q;
	logic [N-1:0]  r_q;
	logic [IW-1:0] i_q;

	// result register
	logic          res_valid_q;
	logic [QW-1:0] quot_q;
	logic [IW-1:0] idx_q;
	logic          last_q;
	logic [IW-1:0] per_q;
	logic          sqerr_q;

	logic                 accept;
	logic                 slot_free;
	logic [W+RW-1:0]      rad_ext;
	logic [W-1:0]         d_in;
	logic [LW-1:0]        lim_in;
	logic                 root_start;
	logic                 root_done;
	logic [H-1:0]         root_val;
	logic                 root_exact;
	logic                 mac_start;
	logic                 mac_done;
	logic signed [PW-1:0] mac_acc;
	logic [H-1:0]         mn_calc;
	logic signed [H:0]    diff;
	logic [N-1:0]         qn;
	logic                 div_start;
	logic                 div_done;
	logic [N-1:0]         div_quot;
	logic [N-1:0]         div_rem;
	logic                 emit0_last;
	logic [IW-1:0]        idx_next;
	logic                 closed;
	logic                 final_term;
	logic                 load;

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == S_IDLE);
	assign slot_free = !res_valid_q || res_ready;

	// only the low RADICAND_BITS bits take part
	assign rad_ext = {{W{1'b0}}, radicand};
	assign d_in    = rad_ext[W-1:0];
	assign lim_in  = (iteration_limit > LW'(MAX_ITERATIONS)) ? LW'(MAX_ITERATIONS)
	                                                         : iteration_limit;

	assign root_start = accept;

	cfe_isqrt #(.ROOT_W(H)) u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.value  (VW'(d_in)),
		.done   (root_done),
		.root   (root_val),
		.exact  (root_exact)
	);

	// m' from the previous remainder; diff = m - m'
	assign mn_calc   = H'(N'(a0_q) - r_q);
	assign diff      = $signed({1'b0, m_q}) - $signed({1'b0, mn_calc});
	assign mac_start = (state_q == S_STEP);

	cfe_mac #(.MULT_W(N), .ACC_W(PW)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.addend ($signed(PW'(qp_q))),
		.mcand  (PW'(diff)),
		.mult   (a_q),
		.done   (mac_done),
		.acc    (mac_acc)
	);

	assign qn        = N'(mac_acc);
	assign div_start = (state_q == S_MUL) && mac_done;

	cfe_div #(.DIV_W(N)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (N'(a0_q) + N'(mn_q)),
		.divisor  (qn),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign emit0_last = sq_q || (lim_q == '0);
	assign idx_next   = i_q + 1'b1;
	assign closed     = (m_q == a0_q) && (q_q == N'(1));
	assign final_term = closed || (idx_next == IW'(lim_q));
	assign load       = slot_free && ((state_q == S_EMIT0) || (state_q == S_EMIT));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (root_done) state_q <= S_EMIT0;
				end
				S_EMIT0: begin
					if (slot_free) state_q <= emit0_last ? S_IDLE : S_STEP;
				end
				S_STEP: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (mac_done) state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (slot_free) state_q <= final_term ? S_IDLE : S_STEP;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// recurrence datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			d_q   <= d_in;
			lim_q <= lim_in;
		end
		if ((state_q == S_ROOT) && root_done) begin
			a0_q <= root_val;
			sq_q <= root_exact;
		end
		if ((state_q == S_EMIT0) && slot_free) begin
			m_q  <= '0;
			q_q  <= N'(1);
			qp_q <= d_q;
			a_q  <= N'(a0_q);
			r_q  <= '0;
			i_q  <= '0;
		end
		if (state_q == S_STEP) begin
			mn_q <= mn_calc;
		end
		if ((state_q == S_MUL) && mac_done) begin
			q_q  <= qn;
			qp_q <= W'(q_q);
			m_q  <= mn_q;
		end
		if ((state_q == S_DIV) && div_done) begin
			a_q <= div_quot;
			r_q <= div_rem;
		end
		if ((state_q == S_EMIT) && slot_free) begin
			i_q <= idx_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (state_q == S_EMIT0) begin
				quot_q  <= QW'(a0_q);
				idx_q   <= '0;
				last_q  <= emit0_last;
				per_q   <= '0;
				sqerr_q <= sq_q;
			end else begin
				quot_q  <= QW'(a_q);
				idx_q   <= idx_next;
				last_q  <= final_term;
				per_q   <= closed ? idx_next : '0;
				sqerr_q <= 1'b0;
			end
		end
	end

	assign res_valid     = res_valid_q;
	assign quotient      = quot_q;
	assign term_index    = idx_q;
	assign last          = last_q;
	assign period_length = per_q;
	assign square_error  = sqerr_q;

endmodule
